/* rtl/core/plt_pkg.sv */
// Shared types, codes and defaults for the positional list insert/delete unit.
`timescale 1ns / 1ps
package plt_pkg;

  // Default sizing handed to the top-level parameters
  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result items
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;   // shift up from pidx, load new value at pidx
    logic             del;   // shift down from pidx
    logic             rd;    // drive the entry at pidx onto the read bus
    logic [POS_W-1:0] pidx;  // zero-based position
  } plt_ctrl_t;

endpackage

/* rtl/core/positional_list_insert_delete_unit.sv */
// Top level of the positional list insert/delete unit: request decode, cell chain, result stage.
// Result: registered; a request accepted at an edge presents its result on out_* in the cycle after.
// Throughput: one request per cycle while out_* is not stalled; every cell compares its index and shifts in that cycle.
// The result register frees in the same cycle it is taken, so back-pressure costs nothing extra.
// Reset: rst_n (synchronous, active low) empties the list and drops any pending result;
// entry contents are not cleared, positions past the length are never read.
`timescale 1ns / 1ps
module positional_list_insert_delete_unit #(
  parameter int unsigned DEPTH      = plt_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = plt_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [39:32] list_length
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > plt_pkg::POS_W + 1) ? CNT_W : plt_pkg::POS_W + 1;

  // Request fields
  logic [plt_pkg::FUNC_W-1:0] func;
  logic [plt_pkg::POS_W-1:0]  position;
  logic [plt_pkg::ITEM_W-1:0] item_value;
  logic                       in_acc;

  assign func       = in_tuser;
  assign position   = in_tdata[7:0];
  assign item_value = in_tdata[39:8];
  assign in_acc     = in_tvalid && in_tready;

  // Length and result registers
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic [plt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [plt_pkg::ITEM_W-1:0]   rdval_r, rdval_nxt;
  logic [plt_pkg::LEN_W-1:0]    len_r, len_nxt;

  assign in_tready = !out_vld_r || out_tready;

  // Position checks on widened copies of position and length
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_after;
  logic             pos_nz;
  logic             in_list;
  logic             in_ins_span;
  logic             is_full;

  assign pos_ext     = {{(CMP_W - plt_pkg::POS_W){1'b0}}, position};
  assign cnt_ext     = {{(CMP_W - CNT_W){1'b0}}, cnt_r};
  assign pos_nz      = (position != '0);
  assign in_list     = pos_nz && (pos_ext <= cnt_ext);
  assign in_ins_span = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1));
  assign is_full     = (cnt_ext == CMP_W'(DEPTH));

  // Decode the request into a chain command and a status
  plt_pkg::plt_ctrl_t          ctrl;
  logic [plt_pkg::STATUS_W-1:0] status_dec;

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.rd    = 1'b0;
    ctrl.pidx  = position - plt_pkg::POS_W'(1);
    status_dec = plt_pkg::ST_RANGE;
    cnt_nxt    = cnt_r;
    case (func)
      plt_pkg::FUNC_READ: begin
        if (in_list) begin
          ctrl.rd    = 1'b1;
          status_dec = plt_pkg::ST_OK;
        end
      end
      plt_pkg::FUNC_INSERT: begin
        if (in_ins_span) begin
          if (is_full) begin
            status_dec = plt_pkg::ST_FULL;
          end else begin
            ctrl.ins   = in_acc;
            status_dec = plt_pkg::ST_OK;
            if (in_acc) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end
      end
      plt_pkg::FUNC_DELETE: begin
        if (in_list) begin
          ctrl.rd    = 1'b1;
          ctrl.del   = in_acc;
          status_dec = plt_pkg::ST_OK;
          if (in_acc) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_dec = plt_pkg::ST_RANGE;
      end
    endcase
  end

  // Fit the inserted value to the entry width
  logic [DATA_WIDTH-1:0] ins_val;
  generate
    if (DATA_WIDTH <= plt_pkg::ITEM_W) begin : g_ins_trunc
      assign ins_val = item_value[DATA_WIDTH-1:0];
    end else begin : g_ins_sext
      assign ins_val = {{(DATA_WIDTH - plt_pkg::ITEM_W){item_value[plt_pkg::ITEM_W-1]}},
                        item_value};
    end
  endgenerate

  // Cell chain
  logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd [DEPTH];

  generate
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_q;
      logic [DATA_WIDTH-1:0] upper_q;
      if (k == 0) begin : g_first
        assign lower_q = '0;
      end else begin : g_mid_lo
        assign lower_q = cell_q[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
        assign upper_q = cell_q[k];
      end else begin : g_mid_hi
        assign upper_q = cell_q[k+1];
      end
      plt_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (k)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .ins_val (ins_val),
        .lower_q (lower_q),
        .upper_q (upper_q),
        .q       (cell_q[k]),
        .rd_q    (cell_rd[k])
      );
    end
  endgenerate

  // Collect the addressed entry from the read bus
  logic [DATA_WIDTH-1:0] rd_bus;
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // Present the entry as a 32-bit signed word
  logic [plt_pkg::ITEM_W-1:0] rd_word;
  generate
    if (DATA_WIDTH >= plt_pkg::ITEM_W) begin : g_rd_trunc
      assign rd_word = rd_bus[plt_pkg::ITEM_W-1:0];
    end else begin : g_rd_sext
      assign rd_word = {{(plt_pkg::ITEM_W - DATA_WIDTH){rd_bus[DATA_WIDTH-1]}}, rd_bus};
    end
  endgenerate

  assign cnt_after = {{(CMP_W - CNT_W){1'b0}}, cnt_nxt};

  // Load a fresh result on accept, drop it once taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    status_nxt  = status_r;
    rdval_nxt   = rdval_r;
    len_nxt     = len_r;
    if (in_acc) begin
      out_vld_nxt = 1'b1;
      status_nxt  = status_dec;
      rdval_nxt   = rd_word;
      len_nxt     = cnt_after[plt_pkg::LEN_W-1:0];
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rdval_r  <= rdval_nxt;
    len_r    <= len_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {len_r, rdval_r};
  assign out_tuser  = status_r;

endmodule

/* rtl/core/plt_cell.sv */
// One storage cell of the list chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
module plt_cell #(
  parameter int unsigned DATA_WIDTH = plt_pkg::DATA_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  plt_pkg::plt_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0] ins_val,
  input  logic [DATA_WIDTH-1:0] lower_q,
  input  logic [DATA_WIDTH-1:0] upper_q,
  output logic [DATA_WIDTH-1:0] q,
  output logic [DATA_WIDTH-1:0] rd_q
);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;
  logic [31:0]           pidx_ext;
  logic                  at_pos;
  logic                  above_pos;

  assign pidx_ext  = {{(32 - plt_pkg::POS_W){1'b0}}, ctrl.pidx};
  assign at_pos    = (pidx_ext == 32'(INDEX));
  assign above_pos = (32'(INDEX) > pidx_ext);

  // Pick the next entry: new value, lower neighbor, upper neighbor or hold
  always_comb begin
    q_nxt = q_r;
    if (ctrl.ins) begin
      if (at_pos) begin
        q_nxt = ins_val;
      end else if (above_pos) begin
        q_nxt = lower_q;
      end
    end else if (ctrl.del) begin
      if (at_pos || above_pos) begin
        q_nxt = upper_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q    = q_r;
  // Gate the entry onto the shared read bus only when addressed
  assign rd_q = (ctrl.rd && at_pos) ? q_r : '0;

endmodule

/* verif/tb_top.sv */
// Testbench for the positional list unit: directed and random requests against a shadow list.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned LIST_DEPTH = plt_pkg::DEPTH_DEF;
  localparam logic [plt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int IDLE_PCT = 9;

  typedef struct packed {
    logic [plt_pkg::FUNC_W-1:0] func;
    logic [plt_pkg::POS_W-1:0]  pos;
    logic [plt_pkg::ITEM_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    logic [plt_pkg::STATUS_W-1:0] status;
    logic [plt_pkg::ITEM_W-1:0]   value;
    logic [plt_pkg::LEN_W-1:0]    length;
  } list_rsp_t;

  typedef enum int {MIX_OPS, GROW_OPS, SHRINK_OPS} op_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [7:0] position, [39:8] item_value
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] read_value, [39:32] list_length
  logic [1:0]  out_tuser;       // [1:0] status

  list_req_t   req_queue[$];
  list_rsp_t   rsp_expected[$];
  logic [plt_pkg::ITEM_W-1:0] shadow_mem[LIST_DEPTH];
  int          shadow_len = 0;
  int          gen_len = 0;
  int          req_taken_cnt = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  bit          req_taken = 1'b0;
  bit          calm;

  positional_list_insert_delete_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // no idling on either side for a stretch of the random part
  assign calm = (req_taken_cnt >= 350) && (req_taken_cnt < 550);

  // apply one request to the shadow list and return the result it should give
  function automatic list_rsp_t list_apply(list_req_t r);
    list_rsp_t rsp;
    int p;
    rsp = '{status: plt_pkg::ST_RANGE, value: '0, length: '0};
    p = int'(r.pos);
    case (r.func)
      plt_pkg::FUNC_READ: begin
        if (p >= 1 && p <= shadow_len) begin
          rsp.value = shadow_mem[p-1];
          rsp.status = plt_pkg::ST_OK;
        end
      end
      plt_pkg::FUNC_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1) begin
          if (shadow_len >= LIST_DEPTH) begin
            rsp.status = plt_pkg::ST_FULL;
          end else begin
            for (int k = shadow_len; k > p - 1; k--) shadow_mem[k] = shadow_mem[k-1];
            shadow_mem[p-1] = r.val;
            shadow_len++;
            rsp.status = plt_pkg::ST_OK;
          end
        end
      end
      plt_pkg::FUNC_DELETE: begin
        if (shadow_len > 0 && p >= 1 && p <= shadow_len) begin
          rsp.value = shadow_mem[p-1];
          for (int k = p - 1; k + 1 < shadow_len; k++) shadow_mem[k] = shadow_mem[k+1];
          shadow_len--;
          rsp.status = plt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    rsp.length = shadow_len[plt_pkg::LEN_W-1:0];
    return rsp;
  endfunction

  // queue a request and follow the length it leaves, to steer later positions
  task automatic push_req(logic [plt_pkg::FUNC_W-1:0] func, int pos,
                          logic [plt_pkg::ITEM_W-1:0] val);
    list_req_t r;
    r.func = func;
    r.pos = pos[plt_pkg::POS_W-1:0];
    r.val = val;
    req_queue.push_back(r);
    if (func == plt_pkg::FUNC_INSERT && pos >= 1 && pos <= gen_len + 1 &&
        gen_len < LIST_DEPTH)
      gen_len++;
    else if (func == plt_pkg::FUNC_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
  endtask

  // queue n random requests, mostly at valid positions of the current list
  task automatic push_random(op_mix_t mix, int n);
    int r;
    int s;
    int pos;
    int ins_lim;
    int del_lim;
    logic [plt_pkg::FUNC_W-1:0] func;
    for (int i = 0; i < n; i++) begin
      case (mix)
        GROW_OPS:   begin ins_lim = 70; del_lim = 80; end
        SHRINK_OPS: begin ins_lim = 10; del_lim = 80; end
        default:    begin ins_lim = 35; del_lim = 65; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_lim) func = plt_pkg::FUNC_INSERT;
      else if (r < del_lim) func = plt_pkg::FUNC_DELETE;
      else if (r < 97) func = plt_pkg::FUNC_READ;
      else func = FUNC_UNUSED;
      s = $urandom_range(0, 99);
      if (s < 85) begin
        if (func == plt_pkg::FUNC_INSERT) pos = $urandom_range(1, gen_len + 1);
        else pos = $urandom_range(1, (gen_len == 0) ? 1 : gen_len);
      end else if (s < 95) begin
        case ($urandom_range(0, 3))
          0: pos = 0;
          1: pos = gen_len;
          2: pos = gen_len + 1;
          default: pos = 255;
        endcase
      end else begin
        pos = $urandom_range(0, 255);
      end
      push_req(func, pos, $urandom);
    end
  endtask

  // wait until every queued request is sent and every expected result has come back
  task automatic drain_all();
    while (req_queue.size() != 0 || rsp_expected.size() != 0) @(posedge clk);
  endtask

  // sender: hold a request until taken, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {req_queue[0].val, req_queue[0].pos};
        in_tuser <= req_queue[0].func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall at random outside the calm stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // predict on each taken request, check each returned result
  always @(posedge clk) begin
    list_req_t r;
    list_rsp_t want;
    req_taken = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      r.func = in_tuser;
      r.pos = in_tdata[7:0];
      r.val = in_tdata[39:8];
      rsp_expected.push_back(list_apply(r));
      void'(req_queue.pop_front());
      req_taken = 1'b1;
      req_taken_cnt++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (rsp_expected.size() == 0) begin
        $error("result with no request outstanding: status %0d value %h length %0d",
               out_tuser, out_tdata[31:0], out_tdata[39:32]);
        err_cnt++;
      end else begin
        want = rsp_expected.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          err_cnt++;
        end
        if (out_tdata[31:0] !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tdata[39:32] !== want.length) begin
          $error("list_length: expected %0d, got %0d", want.length, out_tdata[39:32]);
          err_cnt++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // empty list: every operation is rejected
    push_req(plt_pkg::FUNC_READ, 1, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 1, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 0, 32'h0);
    push_req(plt_pkg::FUNC_INSERT, 0, 32'h1234_5678);
    push_req(plt_pkg::FUNC_INSERT, 2, 32'h1234_5678);
    // build a short list with extreme values, inserting at front, end and middle
    push_req(plt_pkg::FUNC_INSERT, 1, 32'h7fff_ffff);
    push_req(plt_pkg::FUNC_INSERT, 1, 32'h8000_0000);
    push_req(plt_pkg::FUNC_INSERT, 3, 32'hffff_ffff);
    push_req(plt_pkg::FUNC_INSERT, 2, 32'h0000_0000);
    push_req(plt_pkg::FUNC_READ, 0, 32'h0);
    push_req(plt_pkg::FUNC_READ, 1, 32'h0);
    push_req(plt_pkg::FUNC_READ, 2, 32'h0);
    push_req(plt_pkg::FUNC_READ, 4, 32'h0);
    push_req(plt_pkg::FUNC_READ, 5, 32'h0);
    push_req(plt_pkg::FUNC_READ, 255, 32'hffff_ffff);
    push_req(FUNC_UNUSED, 1, 32'hdead_beef);
    push_req(plt_pkg::FUNC_INSERT, 255, 32'h5555_5555);
    // delete last, first, past the end, down to empty
    push_req(plt_pkg::FUNC_DELETE, 4, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 1, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 3, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 1, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 1, 32'h0);
    push_req(plt_pkg::FUNC_DELETE, 1, 32'h0);
    push_req(plt_pkg::FUNC_INSERT, 1, 32'h5a5a_a5a5);

    // hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    drain_all();
    push_random(MIX_OPS, 150);
    push_random(GROW_OPS, 300);
    push_random(MIX_OPS, 150);
    drain_all();
    push_random(SHRINK_OPS, 250);
    push_random(MIX_OPS, 100);
    drain_all();
    repeat (4) @(posedge clk);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/plt_pkg.sv
rtl/core/plt_cell.sv
rtl/core/positional_list_insert_delete_unit.sv
verif/tb_top.sv
